// ----- src/twbi_pkg.sv -----
// Package with the shared constants, field offsets and the sequencer state type.
package twbi_pkg;

    // Fixed day length and fixed-point units.
    localparam int HOURS_PER_DAY = 24;
    localparam logic [12:0] ONE_Q12 = 13'd4096;
    localparam logic [8:0]  ONE_Q8  = 9'd256;
    localparam logic [5:0]  CACHE_RESET = 6'd61;
    localparam logic [5:0]  TIME_MAX    = 6'd59;
    localparam logic [8:0]  BLEND_MAX   = 9'd256;

    // Time fraction t = floor((512*x + 225) / 450), with x = 60*minute + second.
    // The division by 450 is a multiply by the rounded-up reciprocal 2^30/450.
    localparam logic [20:0] FRAC_BIAS   = 21'd225;
    localparam logic [21:0] RECIP_M     = 22'd2386093;
    localparam int          RECIP_SHIFT = 30;

    // Input word layout, lowest bit first.
    localparam int DATA_W        = 48;
    localparam int HOUR_LSB      = 0;
    localparam int MINUTE_LSB    = 5;
    localparam int SECOND_LSB    = 11;
    localparam int OLD_W_LSB     = 17;
    localparam int NEW_W_LSB     = 19;
    localparam int BLEND_LSB     = 21;
    localparam int ENTRY_LSB     = 30;

    // Input mode codes carried in tuser.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Steps of the multiply-accumulate run.
    localparam logic [2:0] RUN_LAST = 3'd6;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FRAC = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

endpackage

// ----- src/time_weather_bilinear_interp_unit.sv -----
// Top level of the time-of-day by weather bilinear interpolator.
//
//  channel  | direction | words carried
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | table write (tuser = 0) or query (tuser = 1)
//  m_axis   | out       | one interpolated Q8.8 value for every query
//
// A table write is taken while idle; a query that hits the cached second goes through
// accept and output load. Any other query goes through accept, time fraction, seven
// steps for the four table reads, multiplies, accumulation and rounding, output load.
// Reset clears the sequencer, the cache key (to 61) and the cached result, not the table.
// A stalled output holds the sequencer in its output state, so no new word is taken.
module time_weather_bilinear_interp_unit #(
    parameter int WEATHER_TYPES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: hour[4:0], minute[10:5], second[16:11], old_weather[18:17],
    //        new_weather[20:19], weather_blend[29:21], entry_value[45:30], zeros
    input  logic [twbi_pkg::DATA_W-1:0] s_axis_tdata,
    // tuser: mode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: result_value[15:0]
    output logic [15:0] m_axis_tdata
);

    localparam int DEPTH = twbi_pkg::HOURS_PER_DAY * WEATHER_TYPES;
    localparam int AW    = $clog2(DEPTH);

    // Field unpacking.
    logic [4:0]        in_hour;
    logic [5:0]        in_minute;
    logic [5:0]        in_second;
    logic [1:0]        in_old_w;
    logic [1:0]        in_new_w;
    logic [8:0]        in_blend;
    logic signed [15:0] in_entry;

    assign in_hour   = s_axis_tdata[twbi_pkg::HOUR_LSB   +: 5];
    assign in_minute = s_axis_tdata[twbi_pkg::MINUTE_LSB +: 6];
    assign in_second = s_axis_tdata[twbi_pkg::SECOND_LSB +: 6];
    assign in_old_w  = s_axis_tdata[twbi_pkg::OLD_W_LSB  +: 2];
    assign in_new_w  = s_axis_tdata[twbi_pkg::NEW_W_LSB  +: 2];
    assign in_blend  = s_axis_tdata[twbi_pkg::BLEND_LSB  +: 9];
    assign in_entry  = $signed(s_axis_tdata[twbi_pkg::ENTRY_LSB +: 16]);

    // Registers.
    twbi_pkg::state_t   state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [5:0]         last_second_reg, last_second_next;
    logic signed [15:0] cached_result_reg, cached_result_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg, out_data_next;
    logic [4:0]         h1_reg, h1_next;
    logic [4:0]         h2_reg, h2_next;
    logic [1:0]         w1_reg, w1_next;
    logic [1:0]         w2_reg, w2_next;
    logic [8:0]         b_reg, b_next;
    logic [20:0]        n_reg, n_next;
    logic [11:0]        t_reg, t_next;
    logic [20:0]        wgt_reg, wgt_next;
    logic signed [36:0] prod_reg, prod_next;
    logic signed [37:0] acc_reg, acc_next;
    logic signed [15:0] rdata_reg;

    // Table memory.
    logic signed [15:0] mem [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    // Helper signals.
    logic        in_acc;
    logic        acc_write;
    logic        acc_query;
    logic        cache_hit;
    logic        out_free;
    logic [5:0]  mi_clamped;
    logic [5:0]  se_clamped;
    logic [11:0] time_x;
    logic [4:0]  hq;
    logic [42:0] tprod;
    logic [4:0]  rd_hour;
    logic [1:0]  rd_weather;
    logic [12:0] tsel;
    logic [8:0]  bsel;
    logic [21:0] wprod;
    logic signed [37:0] biased;
    logic signed [17:0] rounded;
    logic signed [15:0] saturated;

    assign s_axis_tready = (state_reg == twbi_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign acc_write = in_acc && (s_axis_tuser == twbi_pkg::MODE_WRITE);
    assign acc_query = in_acc && (s_axis_tuser == twbi_pkg::MODE_QUERY);
    assign cache_hit = (in_second == last_second_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Clamping and the time numerator of a new query.
    assign mi_clamped = (in_minute > twbi_pkg::TIME_MAX) ? twbi_pkg::TIME_MAX : in_minute;
    assign se_clamped = (in_second > twbi_pkg::TIME_MAX) ? twbi_pkg::TIME_MAX : in_second;
    assign time_x     = 12'(12'(mi_clamped) * 12'd60 + 12'(se_clamped));
    assign hq         = (int'(in_hour) >= twbi_pkg::HOURS_PER_DAY)
                      ? 5'(int'(in_hour) - twbi_pkg::HOURS_PER_DAY) : in_hour;

    // Table write port: out-of-range addresses are dropped.
    assign mem_we    = acc_write && (int'(in_hour) < twbi_pkg::HOURS_PER_DAY)
                     && (int'(in_old_w) < WEATHER_TYPES);
    assign mem_waddr = AW'(int'(in_hour) * WEATHER_TYPES + int'(in_old_w));

    // Read address sequence: step bit 0 picks the hour, bit 1 the weather.
    assign mem_re     = (state_reg == twbi_pkg::ST_RUN) && !cnt_reg[2];
    assign rd_hour    = cnt_reg[0] ? h2_reg : h1_reg;
    assign rd_weather = cnt_reg[1] ? w2_reg : w1_reg;
    assign mem_raddr  = AW'(int'(rd_hour) * WEATHER_TYPES + int'(rd_weather));

    // Time fraction by reciprocal multiplication.
    assign tprod = 43'(n_reg) * 43'(twbi_pkg::RECIP_M);

    // Weight of the entry read in the same step.
    assign tsel  = cnt_reg[0] ? {1'b0, t_reg} : 13'(twbi_pkg::ONE_Q12 - {1'b0, t_reg});
    assign bsel  = cnt_reg[1] ? b_reg : 9'(twbi_pkg::ONE_Q8 - b_reg);
    assign wprod = 22'(tsel) * 22'(bsel);

    // Round half up at bit 20, then saturate to Q8.8.
    assign biased  = acc_reg + 38'sd524288;
    assign rounded = biased[37:20];
    always_comb
    begin
        if (rounded > 18'sd32767)
            saturated = 16'sh7FFF;
        else if (rounded < -18'sd32768)
            saturated = -16'sh8000;
        else
            saturated = rounded[15:0];
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        last_second_next   = last_second_reg;
        cached_result_next = cached_result_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        h1_next            = h1_reg;
        h2_next            = h2_reg;
        w1_next            = w1_reg;
        w2_next            = w2_reg;
        b_next             = b_reg;
        n_next             = n_reg;
        t_next             = t_reg;
        wgt_next           = wgt_reg;
        prod_next          = prod_reg;
        acc_next           = acc_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            twbi_pkg::ST_IDLE:
            begin
                if (acc_query)
                begin
                    h1_next = hq;
                    h2_next = (int'(hq) == twbi_pkg::HOURS_PER_DAY - 1) ? 5'd0 : 5'(hq + 5'd1);
                    w1_next = (int'(in_old_w) >= WEATHER_TYPES)
                            ? 2'(WEATHER_TYPES - 1) : in_old_w;
                    w2_next = (int'(in_new_w) >= WEATHER_TYPES)
                            ? 2'(WEATHER_TYPES - 1) : in_new_w;
                    b_next  = (in_blend > twbi_pkg::BLEND_MAX) ? twbi_pkg::BLEND_MAX : in_blend;
                    n_next  = {time_x, 9'd0} + twbi_pkg::FRAC_BIAS;
                    if (cache_hit)
                        state_next = twbi_pkg::ST_OUT;
                    else
                    begin
                        last_second_next = in_second;
                        state_next       = twbi_pkg::ST_FRAC;
                    end
                end
            end
            twbi_pkg::ST_FRAC:
            begin
                t_next     = tprod[twbi_pkg::RECIP_SHIFT +: 12];
                acc_next   = '0;
                cnt_next   = '0;
                state_next = twbi_pkg::ST_RUN;
            end
            twbi_pkg::ST_RUN:
            begin
                // Weight for the entry whose read goes out in this step.
                if (!cnt_reg[2])
                    wgt_next = wprod[20:0];
                // Entry times weight, in the step after the read.
                if ((cnt_reg >= 3'd1) && (cnt_reg <= 3'd4))
                    prod_next = 37'(rdata_reg) * 37'($signed({1'b0, wgt_reg}));
                // Accumulate, in the step after the multiply.
                if ((cnt_reg >= 3'd2) && (cnt_reg <= 3'd5))
                    acc_next = acc_reg + 38'(prod_reg);
                if (cnt_reg == twbi_pkg::RUN_LAST)
                begin
                    cached_result_next = saturated;
                    state_next         = twbi_pkg::ST_OUT;
                end
                else
                    cnt_next = 3'(cnt_reg + 3'd1);
            end
            twbi_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = cached_result_reg;
                    state_next     = twbi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twbi_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= twbi_pkg::ST_IDLE;
            cnt_reg           <= '0;
            last_second_reg   <= twbi_pkg::CACHE_RESET;
            cached_result_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            last_second_reg   <= last_second_next;
            cached_result_reg <= cached_result_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        h1_reg       <= h1_next;
        h2_reg       <= h2_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        b_reg        <= b_next;
        n_reg        <= n_next;
        t_reg        <= t_next;
        wgt_reg      <= wgt_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
    end

    // Table memory: writes are taken only when idle and reads only while a
    // query runs, so the two ports never touch an entry in the same cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= in_entry;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // The table is never written while a query is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == twbi_pkg::ST_IDLE))
        else $error("table write outside idle state");

    // A cache hit goes straight to the output and keeps the cached value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_query && cache_hit) |=>
            ((state_reg == twbi_pkg::ST_OUT) && $stable(cached_result_reg)))
        else $error("cache hit did not reuse cached result");

    // A cache miss records its second as the new key.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_query && !cache_hit) |=>
            ((last_second_reg == $past(in_second)) && (state_reg == twbi_pkg::ST_FRAC)))
        else $error("cache miss did not update key");

    // The step counter stays within the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twbi_pkg::ST_RUN) |-> (cnt_reg <= twbi_pkg::RUN_LAST))
        else $error("run step counter out of range");

endmodule

// ----- verif/time_weather_bilinear_interp_checker.sv -----
// Checker that predicts the interpolated values and compares them with the output stream.
module time_weather_bilinear_interp_checker #(
    parameter int WEATHER_TYPES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [twbi_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    output int          failures,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Own copy of the table, the cache key and the cached value.
    logic signed [15:0] entry_grid [0:twbi_pkg::HOURS_PER_DAY*WEATHER_TYPES-1];
    logic [5:0]         cache_second;
    logic [15:0]        cache_value;
    logic [15:0]        values_due [$];
    logic [15:0]        want;

    // Fields of the word on the input side.
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [1:0]  in_old_w;
    logic [1:0]  in_new_w;
    logic [8:0]  in_blend;
    logic [15:0] in_entry;

    assign in_hour   = s_axis_tdata[twbi_pkg::HOUR_LSB +: 5];
    assign in_minute = s_axis_tdata[twbi_pkg::MINUTE_LSB +: 6];
    assign in_second = s_axis_tdata[twbi_pkg::SECOND_LSB +: 6];
    assign in_old_w  = s_axis_tdata[twbi_pkg::OLD_W_LSB +: 2];
    assign in_new_w  = s_axis_tdata[twbi_pkg::NEW_W_LSB +: 2];
    assign in_blend  = s_axis_tdata[twbi_pkg::BLEND_LSB +: 9];
    assign in_entry  = s_axis_tdata[twbi_pkg::ENTRY_LSB +: 16];

    // Weather types past the last column fall back to the last column.
    function automatic int weather_column(input logic [1:0] w);
        return (int'(w) >= WEATHER_TYPES) ? WEATHER_TYPES - 1 : int'(w);
    endfunction

    // Bilinear blend over the hour and the weather, rounded and saturated to Q8.8.
    function automatic logic [15:0] bilinear_value(
        input logic [4:0] hour,
        input logic [5:0] minute,
        input logic [5:0] second,
        input logic [1:0] old_w,
        input logic [1:0] new_w,
        input logic [8:0] blend
    );
        int     h_now;
        int     h_next;
        int     w_old;
        int     w_new;
        longint mins;
        longint secs;
        longint mix;
        longint frac;
        longint c0;
        longint c1;
        longint c2;
        longint c3;
        longint acc;
        longint rounded;
        h_now  = int'(hour) % twbi_pkg::HOURS_PER_DAY;
        h_next = (h_now + 1) % twbi_pkg::HOURS_PER_DAY;
        w_old  = weather_column(old_w);
        w_new  = weather_column(new_w);
        mins   = longint'(minute);
        secs   = longint'(second);
        mix    = longint'(blend);
        if (mins > longint'(twbi_pkg::TIME_MAX))
            mins = longint'(twbi_pkg::TIME_MAX);
        if (secs > longint'(twbi_pkg::TIME_MAX))
            secs = longint'(twbi_pkg::TIME_MAX);
        if (mix > longint'(twbi_pkg::BLEND_MAX))
            mix = longint'(twbi_pkg::BLEND_MAX);
        // Fraction of the hour in Q0.12, rounded half up.
        frac = ((60 * mins + secs) * longint'(twbi_pkg::ONE_Q12) + 1800) / 3600;
        c0 = (longint'(twbi_pkg::ONE_Q12) - frac) * (longint'(twbi_pkg::ONE_Q8) - mix);
        c1 = frac * (longint'(twbi_pkg::ONE_Q8) - mix);
        c2 = (longint'(twbi_pkg::ONE_Q12) - frac) * mix;
        c3 = frac * mix;
        acc = longint'(entry_grid[h_now * WEATHER_TYPES + w_old]) * c0
            + longint'(entry_grid[h_next * WEATHER_TYPES + w_old]) * c1
            + longint'(entry_grid[h_now * WEATHER_TYPES + w_new]) * c2
            + longint'(entry_grid[h_next * WEATHER_TYPES + w_new]) * c3;
        rounded = (acc + (longint'(1) << 19)) >>> 20;
        if (rounded > 32767)
            rounded = 32767;
        if (rounded < -32768)
            rounded = -32768;
        return rounded[15:0];
    endfunction

    // Results are checked before the input word of the same edge is taken in.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (entry_grid[i])
                entry_grid[i] = '0;
            cache_second = twbi_pkg::CACHE_RESET;
            cache_value  = '0;
            values_due.delete();
            failures     = 0;
            pending      = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (values_due.size() == 0)
                begin
                    $display("%0t: result_value expected none, got %0d", $time,
                             $signed(m_axis_tdata));
                    failures = failures + 1;
                end
                else
                begin
                    want = values_due.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: result_value expected %0d, got %0d", $time,
                                 $signed(want), $signed(m_axis_tdata));
                        failures = failures + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == twbi_pkg::MODE_WRITE)
                begin
                    // Writes outside the table are dropped.
                    if (int'(in_hour) < twbi_pkg::HOURS_PER_DAY
                        && int'(in_old_w) < WEATHER_TYPES)
                        entry_grid[int'(in_hour) * WEATHER_TYPES + int'(in_old_w)] = in_entry;
                end
                else
                begin
                    // A query on the same second as the last computed one reuses it.
                    if (in_second != cache_second)
                    begin
                        cache_value  = bilinear_value(in_hour, in_minute, in_second,
                                                      in_old_w, in_new_w, in_blend);
                        cache_second = in_second;
                    end
                    values_due.push_back(cache_value);
                end
            end
            pending = values_due.size();
        end
    end

endmodule

// ----- verif/time_weather_bilinear_interp_unit_test.sv -----
// Top of the interpolator testbench: clock, reset, stimulus and the final verdict.
module time_weather_bilinear_interp_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WEATHER_TYPES = 4;
    localparam int RANDOM_WORDS  = 936;
    localparam int STEADY_FROM   = 840;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [twbi_pkg::DATA_W-1:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    int          failures;
    int          pending;

    // Idling controls for the sender and the receiver, and the last query second.
    int          gap_pct;
    int          stall_pct;
    bit          steady;
    logic [5:0]  last_query_second;

    time_weather_bilinear_interp_unit #(
        .WEATHER_TYPES(WEATHER_TYPES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    time_weather_bilinear_interp_checker #(
        .WEATHER_TYPES(WEATHER_TYPES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .failures(failures),
        .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Present one word and hold it until taken, then maybe idle for a burst.
    task automatic send_word(
        input logic        mode,
        input logic [4:0]  hour,
        input logic [5:0]  minute,
        input logic [5:0]  second,
        input logic [1:0]  old_w,
        input logic [1:0]  new_w,
        input logic [8:0]  blend,
        input logic [15:0] entry
    );
        logic [twbi_pkg::DATA_W-1:0] word;
        word = '0;
        word[twbi_pkg::HOUR_LSB +: 5]   = hour;
        word[twbi_pkg::MINUTE_LSB +: 6] = minute;
        word[twbi_pkg::SECOND_LSB +: 6] = second;
        word[twbi_pkg::OLD_W_LSB +: 2]  = old_w;
        word[twbi_pkg::NEW_W_LSB +: 2]  = new_w;
        word[twbi_pkg::BLEND_LSB +: 9]  = blend;
        word[twbi_pkg::ENTRY_LSB +: 16] = entry;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (mode == twbi_pkg::MODE_QUERY)
            last_query_second = second;
        if (!steady && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // One random word: mostly queries over the whole table, some writes,
    // a share of them aimed outside the table or at the cached second.
    task automatic send_random_word();
        logic        mode;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [8:0]  blend;
        mode   = ($urandom_range(0, 99) < 75) ? twbi_pkg::MODE_QUERY : twbi_pkg::MODE_WRITE;
        hour   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                             : 5'($urandom_range(0, 23));
        minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                             : 6'($urandom_range(0, 59));
        second = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                             : 6'($urandom_range(0, 59));
        if (mode == twbi_pkg::MODE_QUERY && $urandom_range(0, 99) < 30)
            second = last_query_second;
        blend  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(257, 511))
                                             : 9'($urandom_range(0, 256));
        send_word(mode, hour, minute, second, 2'($urandom), 2'($urandom), blend,
                  16'($urandom));
    endtask

    // Receiver: stalls in random bursts, never in the steady tail.
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!steady && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("time_weather_bilinear_interp_unit regression: fail");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tuser      = twbi_pkg::MODE_WRITE;
        gap_pct           = 20;
        stall_pct         = 20;
        steady            = 1'b0;
        last_query_second = twbi_pkg::CACHE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset the cache key matches second 61 and gives zero.
        send_word(twbi_pkg::MODE_QUERY, 5'd3, 6'd10, 6'd61, 2'd0, 2'd1, 9'd100, 16'h0000);

        // Fill every entry so that no query reads an unwritten one.
        for (int h = 0; h < twbi_pkg::HOURS_PER_DAY; h++)
            for (int w = 0; w < WEATHER_TYPES; w++)
                send_word(twbi_pkg::MODE_WRITE, 5'(h), 6'($urandom), 6'($urandom), 2'(w),
                          2'($urandom), 9'($urandom), 16'($urandom));

        // Extreme entries around hour 5 for weathers 1 and 2.
        send_word(twbi_pkg::MODE_WRITE, 5'd5, 6'd0, 6'd0, 2'd1, 2'd0, 9'd0, 16'h7FFF);
        send_word(twbi_pkg::MODE_WRITE, 5'd6, 6'd0, 6'd0, 2'd1, 2'd0, 9'd0, 16'h7FFF);
        send_word(twbi_pkg::MODE_WRITE, 5'd5, 6'd0, 6'd0, 2'd2, 2'd0, 9'd0, 16'h8000);
        send_word(twbi_pkg::MODE_WRITE, 5'd6, 6'd0, 6'd0, 2'd2, 2'd0, 9'd0, 16'h8000);
        // Start of the hour, end of the hour, full blend.
        send_word(twbi_pkg::MODE_QUERY, 5'd5, 6'd0, 6'd0, 2'd1, 2'd2, 9'd0, 16'h0000);
        send_word(twbi_pkg::MODE_QUERY, 5'd5, 6'd59, 6'd59, 2'd1, 2'd2, 9'd0, 16'hFFFF);
        send_word(twbi_pkg::MODE_QUERY, 5'd5, 6'd30, 6'd1, 2'd1, 2'd2, 9'd256, 16'h0000);
        // Blend above one and minute past 59.
        send_word(twbi_pkg::MODE_QUERY, 5'd5, 6'd63, 6'd2, 2'd1, 2'd2, 9'd511, 16'h0000);
        // Hour past the day wraps round; second past 59 is still the cache key.
        send_word(twbi_pkg::MODE_QUERY, 5'd29, 6'd10, 6'd63, 2'd2, 2'd1, 9'd128, 16'h0000);
        // Same second with other fields: cached value comes back.
        send_word(twbi_pkg::MODE_QUERY, 5'd0, 6'd0, 6'd63, 2'd3, 2'd0, 9'd0, 16'h0000);
        // A write outside the table is dropped; a table write keeps the cache.
        send_word(twbi_pkg::MODE_WRITE, 5'd30, 6'd0, 6'd0, 2'd0, 2'd0, 9'd0, 16'h1234);
        send_word(twbi_pkg::MODE_WRITE, 5'd23, 6'd0, 6'd0, 2'd3, 2'd0, 9'd0, 16'hFFFF);
        send_word(twbi_pkg::MODE_QUERY, 5'd23, 6'd0, 6'd63, 2'd3, 2'd0, 9'd0, 16'h0000);
        // Last hour blends into the first; hour 31 wraps to 7.
        send_word(twbi_pkg::MODE_QUERY, 5'd23, 6'd45, 6'd10, 2'd3, 2'd0, 9'd128, 16'h0000);
        send_word(twbi_pkg::MODE_QUERY, 5'd31, 6'd20, 6'd11, 2'd0, 2'd3, 9'd300, 16'h0000);
        send_word(twbi_pkg::MODE_QUERY, 5'd0, 6'd59, 6'd62, 2'd0, 2'd0, 9'd1, 16'h0000);
        send_word(twbi_pkg::MODE_QUERY, 5'd12, 6'd0, 6'd30, 2'd3, 2'd3, 9'd255, 16'h0000);

        // Random part; idling strength changes every 64 words, none at the end.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end
                    1:
                    begin
                        gap_pct   = 15;
                        stall_pct = 15;
                    end
                    default:
                    begin
                        gap_pct   = 40;
                        stall_pct = 40;
                    end
                endcase
            end
            if (n == STEADY_FROM)
                steady = 1'b1;
            send_random_word();
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow the block's latency once more.
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("time_weather_bilinear_interp_unit regression: pass");
        else
            $display("time_weather_bilinear_interp_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/twbi_pkg.sv
src/time_weather_bilinear_interp_unit.sv
verif/time_weather_bilinear_interp_checker.sv
verif/time_weather_bilinear_interp_unit_test.sv
